// ===== rtl/evds_pkg.sv =====
// ----------------------------------------------------------------------------
// evds_pkg
// Shared types and constants of the event duration statistics block.
// ----------------------------------------------------------------------------
package evds_pkg;

	localparam int SAMPLE_LIMIT = 1024;
	localparam int EVENT_TYPES  = 16;

	localparam int OP_W   = 3;
	localparam int TYPE_W = 8;
	localparam int DUR_W  = 32;
	localparam int CNT_W  = 11;
	localparam int TOT_W  = 42;
	localparam int CODE_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam int TIDX_W = (EVENT_TYPES > 1) ? $clog2(EVENT_TYPES) : 1;
	localparam int STEP_W = $clog2(TOT_W + 1);

	typedef enum logic [OP_W-1:0] {
		OP_RECORD = 3'd0,
		OP_START  = 3'd1,
		OP_STOP   = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT_CODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MISS_CODE   = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [TYPE_W-1:0] etype;
		logic [DUR_W-1:0]  duration;
	} sample_t;

	typedef struct packed {
		logic              accepted;
		logic              collecting;
		logic [CNT_W-1:0]  samples_taken;
		logic              type_tracked;
		logic [CNT_W-1:0]  type_count;
		logic [DUR_W-1:0]  min_duration;
		logic [DUR_W-1:0]  max_duration;
		logic [TOT_W-1:0]  dur_total;
		logic [DUR_W-1:0]  avg_duration;
		logic [CNT_W-1:0]  context_switches;
		logic [CNT_W-1:0]  page_faults;
		logic [CNT_W-1:0]  cache_misses;
	} result_t;

	typedef struct packed {
		logic capture;
		logic execute;
		logic div_start;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/event_duration_statistics.sv =====
// ----------------------------------------------------------------------------
// event_duration_statistics
// Per event type count, min, max, total and mean of sample durations.
// ----------------------------------------------------------------------------
// a beat passes the update, divider start, divide and write-back states before its result
// is loaded; divide waits on the 42-step bit-serial mean divider, write-back on a free output
// the next beat is taken after write-back, even while the result still waits in the output register
// reset: collection off, all statistics empty, class codes 0, 1 and 2
module event_duration_statistics
	import evds_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  sample_t              sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CODE_W-1:0]    cfg_data
);

	cmd_t    cmd;
	status_t status;

	evds_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.status       (status),
		.cmd          (cmd)
	);

	evds_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== rtl/evds_div.sv =====
// ----------------------------------------------------------------------------
// evds_div
// Restoring divider, one quotient bit per cycle, for the mean duration.
// ----------------------------------------------------------------------------
module evds_div
	import evds_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [TOT_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [TOT_W-1:0] quotient
);

	logic [TOT_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [STEP_W-1:0] left_q;
	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    rem_sub;
	logic              fits;

	assign rem_sh  = {rem_q, quo_q[TOT_W-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign fits    = (rem_sh >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (start) begin
			left_q <= STEP_W'(TOT_W);
		end else if (left_q != '0) begin
			left_q <= left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (left_q != '0) begin
			quo_q <= {quo_q[TOT_W-2:0], fits};
			rem_q <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

	assign done     = (left_q == '0);
	assign quotient = quo_q;

endmodule

// ===== rtl/evds_datapath.sv =====
// ----------------------------------------------------------------------------
// evds_datapath
// Statistics storage, sample update, mean divider and result register.
// ----------------------------------------------------------------------------
module evds_datapath
	import evds_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  sample_t              sample,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CODE_W-1:0]    cfg_data,
	input  cmd_t                 cmd,
	output status_t              status,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result
);

	logic [CODE_W-1:0] switch_code_q, fault_code_q, miss_code_q;

	sample_t          sample_q;
	logic             acc_q;
	logic             active_q;
	logic [CNT_W-1:0] taken_q;
	logic [CNT_W-1:0] switch_q, fault_q, miss_q;

	logic [EVENT_TYPES-1:0] valid_q;
	logic [CNT_W-1:0]       cnt_q [EVENT_TYPES];
	logic [DUR_W-1:0]       min_q [EVENT_TYPES];
	logic [DUR_W-1:0]       max_q [EVENT_TYPES];
	logic [TOT_W-1:0]       tot_q [EVENT_TYPES];

	logic              out_valid_q;
	result_t           result_q;

	logic [TIDX_W-1:0] idx;
	logic              tracked;
	logic              hit;
	logic              take;
	logic              wipe;
	logic [CNT_W-1:0]  rd_cnt;
	logic [DUR_W-1:0]  rd_min, rd_max;
	logic [TOT_W-1:0]  rd_tot;
	logic              div_done;
	logic [TOT_W-1:0]  quotient;

	assign idx     = sample_q.etype[TIDX_W-1:0];
	assign tracked = ({1'b0, sample_q.etype} < (TYPE_W+1)'(EVENT_TYPES));
	assign hit     = tracked && valid_q[idx];
	assign rd_cnt  = hit ? cnt_q[idx] : '0;
	assign rd_min  = hit ? min_q[idx] : '0;
	assign rd_max  = hit ? max_q[idx] : '0;
	assign rd_tot  = hit ? tot_q[idx] : '0;

	assign take = cmd.execute && (op_t'(sample_q.op) == OP_RECORD) && active_q
		&& (taken_q < CNT_W'(SAMPLE_LIMIT));
	assign wipe = cmd.execute && ((op_t'(sample_q.op) == OP_START)
		|| (op_t'(sample_q.op) == OP_CLEAR));

	// configuration codes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_code_q <= CODE_W'(0);
			fault_code_q  <= CODE_W'(1);
			miss_code_q   <= CODE_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SWITCH_CODE: switch_code_q <= cfg_data;
				CFG_FAULT_CODE:  fault_code_q  <= cfg_data;
				CFG_MISS_CODE:   miss_code_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
		end
	end

	// global counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= 1'b0;
			active_q <= 1'b0;
			taken_q  <= '0;
			switch_q <= '0;
			fault_q  <= '0;
			miss_q   <= '0;
			valid_q  <= '0;
		end else if (cmd.execute) begin
			acc_q <= take;
			if (wipe) begin
				taken_q  <= '0;
				switch_q <= '0;
				fault_q  <= '0;
				miss_q   <= '0;
				valid_q  <= '0;
			end else if (take) begin
				taken_q <= taken_q + 1'b1;
				priority if (sample_q.etype == switch_code_q) begin
					switch_q <= switch_q + 1'b1;
				end else if (sample_q.etype == fault_code_q) begin
					fault_q <= fault_q + 1'b1;
				end else if (sample_q.etype == miss_code_q) begin
					miss_q <= miss_q + 1'b1;
				end
				if (tracked) begin
					valid_q[idx] <= 1'b1;
				end
			end
			if (op_t'(sample_q.op) == OP_START) begin
				active_q <= 1'b1;
			end else if (op_t'(sample_q.op) == OP_STOP) begin
				active_q <= 1'b0;
			end
		end
	end

	// per-type statistics
	always_ff @(posedge clk) begin
		if (take && tracked) begin
			if (!valid_q[idx]) begin
				cnt_q[idx] <= CNT_W'(1);
				min_q[idx] <= sample_q.duration;
				max_q[idx] <= sample_q.duration;
				tot_q[idx] <= TOT_W'(sample_q.duration);
			end else begin
				cnt_q[idx] <= cnt_q[idx] + 1'b1;
				tot_q[idx] <= tot_q[idx] + TOT_W'(sample_q.duration);
				if (sample_q.duration < min_q[idx]) begin
					min_q[idx] <= sample_q.duration;
				end
				if (sample_q.duration > max_q[idx]) begin
					max_q[idx] <= sample_q.duration;
				end
			end
		end
	end

	evds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_tot),
		.divisor  (rd_cnt),
		.done     (div_done),
		.quotient (quotient)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q.accepted         <= acc_q;
			result_q.collecting       <= active_q;
			result_q.samples_taken    <= taken_q;
			result_q.type_tracked     <= hit;
			result_q.type_count       <= rd_cnt;
			result_q.min_duration     <= rd_min;
			result_q.max_duration     <= rd_max;
			result_q.dur_total        <= rd_tot;
			result_q.avg_duration     <= hit ? quotient[DUR_W-1:0] : '0;
			result_q.context_switches <= switch_q;
			result_q.page_faults      <= fault_q;
			result_q.cache_misses     <= miss_q;
		end
	end

	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || result_ready;
	assign result_valid    = out_valid_q;
	assign result          = result_q;

endmodule

// ===== rtl/evds_ctrl.sv =====
// ----------------------------------------------------------------------------
// evds_ctrl
// Sequencer: capture, update, divide and result hand-off for one beat.
// ----------------------------------------------------------------------------
module evds_ctrl
	import evds_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_START = 5'b00100,
		S_DIV   = 5'b01000,
		S_WB    = 5'b10000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = sample_valid;
				if (sample_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.execute = 1'b1;
				state_nxt   = S_START;
			end
			S_START: begin
				cmd.div_start = 1'b1;
				state_nxt     = S_DIV;
			end
			S_DIV: begin
				if (status.div_done) begin
					state_nxt = S_WB;
				end
			end
			S_WB: begin
				cmd.load_out = status.out_free;
				if (status.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	assign sample_ready = (state_q == S_IDLE);

endmodule
